@@ design/tksl_pkg.sv @@
// Shared types and constants for the top-k sorted list.
// Command, status and state codes, control and flag bundles.
// No dependencies.
package tksl_pkg;

  localparam int DEF_LIST_DEPTH = 16;
  localparam int DEF_KEY_BITS   = 32;

  localparam logic [4:0] LIMIT_RESET    = 5'd16;
  localparam logic [0:0] REG_LIST_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_REJECT = 2'd1,
    ST_MISS   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_POS    = 2'd0,
    RES_ENTRY  = 2'd1,
    RES_REJECT = 2'd2,
    RES_FAIL   = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FIND,
    S_DELETE,
    S_READ,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic j_clr;
    logic j_inc;
    logic do_insert;
    logic do_delete;
    logic set_res;
    res_t res_sel;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t in_cmd;
    logic full;
    logic j_in;
    logic key_lt;
    logic key_le;
    logic pay_eq;
    logic rank_ok;
    logic out_free;
  } dp_flags_t;

endpackage

@@ design/tksl_ctrl.sv @@
// Controller for the top-k sorted list: sequences insert, delete, read and find.
// Depends on tksl_pkg.
module tksl_ctrl import tksl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_flags_t flags,
  output ctrl_cmd_t ctrl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (flags.in_cmd)
            CMD_INSERT: state_next = S_CHECK;
            CMD_DELETE: state_next = S_DELETE;
            CMD_READ:   state_next = S_READ;
            default:    state_next = S_FIND;
          endcase
        end
      end
      S_CHECK: begin
        if (flags.full && flags.key_le) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!(flags.j_in && flags.key_lt)) begin
          state_next = S_DONE;
        end
      end
      S_FIND: begin
        if (!flags.j_in || flags.pay_eq) begin
          state_next = S_DONE;
        end
      end
      S_DELETE: state_next = S_DONE;
      S_READ:   state_next = S_DONE;
      S_DONE: begin
        if (flags.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        ctrl.capture = in_valid;
      end
      S_CHECK: begin
        if (flags.full && flags.key_le) begin
          ctrl.set_res = 1'b1;
          ctrl.res_sel = RES_REJECT;
        end else begin
          ctrl.j_clr = 1'b1;
        end
      end
      S_SCAN: begin
        if (flags.j_in && flags.key_lt) begin
          ctrl.j_inc = 1'b1;
        end else begin
          ctrl.do_insert = 1'b1;
          ctrl.set_res   = 1'b1;
          ctrl.res_sel   = RES_POS;
        end
      end
      S_FIND: begin
        if (!flags.j_in) begin
          ctrl.set_res = 1'b1;
          ctrl.res_sel = RES_FAIL;
        end else if (flags.pay_eq) begin
          ctrl.set_res = 1'b1;
          ctrl.res_sel = RES_ENTRY;
        end else begin
          ctrl.j_inc = 1'b1;
        end
      end
      S_DELETE: begin
        ctrl.set_res = 1'b1;
        if (flags.rank_ok) begin
          ctrl.do_delete = 1'b1;
          ctrl.res_sel   = RES_POS;
        end else begin
          ctrl.res_sel = RES_FAIL;
        end
      end
      S_READ: begin
        ctrl.set_res = 1'b1;
        ctrl.res_sel = flags.rank_ok ? RES_ENTRY : RES_FAIL;
      end
      S_DONE: begin
        ctrl.load_out = flags.out_free;
      end
      default: ctrl = '0;
    endcase
  end

endmodule

@@ design/tksl_dp.sv @@
// Datapath for the top-k sorted list: ranked cells, scan index, entry count,
// pending result and output register. Depends on tksl_pkg.
module tksl_dp import tksl_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   ctrl,
  output dp_flags_t   flags,
  input  logic [4:0]  list_limit,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] payload,
  input  logic [3:0]  rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] entry_key,
  output logic [31:0] entry_payload,
  output logic [3:0]  entry_rank,
  output logic [4:0]  entry_count
);

  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [KEY_BITS-1:0] keys [LIST_DEPTH];
  logic [31:0]         pays [LIST_DEPTH];

  logic [CW-1:0]       count;
  logic [CW-1:0]       eff_limit;
  logic [CW-1:0]       top;
  logic [CW-1:0]       j;
  logic                full;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] key_j;
  logic [31:0]         pay_q;
  logic [31:0]         pay_j;
  logic [3:0]          rank_q;

  status_t             res_status;
  logic [31:0]         res_key;
  logic [31:0]         res_pay;
  logic [3:0]          res_rank;

  always_comb begin
    if (list_limit == '0) begin
      eff_limit = CW'(1);
    end else if (32'(list_limit) > 32'(LIST_DEPTH)) begin
      eff_limit = CW'(LIST_DEPTH);
    end else begin
      eff_limit = CW'(list_limit);
    end
  end

  assign full  = (count >= eff_limit);
  assign top   = full ? CW'(count - CW'(1)) : count;
  assign key_j = keys[j[IW-1:0]];
  assign pay_j = pays[j[IW-1:0]];

  assign flags.in_cmd   = cmd_t'(cmd);
  assign flags.full     = full;
  assign flags.j_in     = (j < count);
  assign flags.key_lt   = (key_q < key_j);
  assign flags.key_le   = (key_q <= key_j);
  assign flags.pay_eq   = (pay_j == pay_q);
  assign flags.rank_ok  = (32'(rank_q) < 32'(count));
  assign flags.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      key_q  <= KEY_BITS'(key);
      pay_q  <= payload;
      rank_q <= rank;
      case (cmd_t'(cmd))
        CMD_INSERT: j <= CW'(count - CW'(1));
        CMD_FIND:   j <= '0;
        default:    j <= CW'(rank);
      endcase
    end else if (ctrl.j_clr) begin
      j <= '0;
    end else if (ctrl.j_inc) begin
      j <= CW'(j + CW'(1));
    end
  end

  for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
    logic [KEY_BITS-1:0] prev_key;
    logic [31:0]         prev_pay;
    logic [KEY_BITS-1:0] next_key;
    logic [31:0]         next_pay;

    if (gi == 0) begin : g_first
      assign prev_key = key_q;
      assign prev_pay = pay_q;
    end else begin : g_prev
      assign prev_key = keys[gi-1];
      assign prev_pay = pays[gi-1];
    end

    if (gi == LIST_DEPTH - 1) begin : g_last
      assign next_key = keys[gi];
      assign next_pay = pays[gi];
    end else begin : g_next
      assign next_key = keys[gi+1];
      assign next_pay = pays[gi+1];
    end

    always_ff @(posedge clk) begin
      if (ctrl.do_insert) begin
        if (CW'(gi) == j) begin
          keys[gi] <= key_q;
          pays[gi] <= pay_q;
        end else if (CW'(gi) > j && CW'(gi) <= top) begin
          keys[gi] <= prev_key;
          pays[gi] <= prev_pay;
        end
      end else if (ctrl.do_delete) begin
        if (CW'(gi) >= j && CW'(gi + 1) < count) begin
          keys[gi] <= next_key;
          pays[gi] <= next_pay;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.do_insert && !full) begin
      count <= CW'(count + CW'(1));
    end else if (ctrl.do_delete) begin
      count <= CW'(count - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.set_res) begin
      case (ctrl.res_sel)
        RES_POS: begin
          res_status <= ST_DONE;
          res_key    <= '0;
          res_pay    <= '0;
          res_rank   <= 4'(j);
        end
        RES_ENTRY: begin
          res_status <= ST_DONE;
          res_key    <= 32'(key_j);
          res_pay    <= pay_j;
          res_rank   <= 4'(j);
        end
        RES_REJECT: begin
          res_status <= ST_REJECT;
          res_key    <= '0;
          res_pay    <= '0;
          res_rank   <= '0;
        end
        default: begin
          res_status <= ST_MISS;
          res_key    <= '0;
          res_pay    <= '0;
          res_rank   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      status        <= res_status;
      entry_key     <= res_key;
      entry_payload <= res_pay;
      entry_rank    <= res_rank;
      entry_count   <= 5'(count);
    end
  end

endmodule

@@ design/top_k_sorted_list.sv @@
// Top level of the top-k sorted list: register port, controller and datapath.
// Depends on tksl_pkg, tksl_ctrl and tksl_dp.
//
// Keeps up to list_limit (1..LIST_DEPTH) key/payload entries by descending key.
// Input channel: cmd, key, payload, rank with in_valid / in_stall; a
// transaction is taken when in_valid is high and in_stall is low.
// Output channel: status, entry_key, entry_payload, entry_rank, entry_count
// with out_valid / out_stall; one result per input transaction, in order.
// One transaction is worked on at a time; the scan walks one rank per cycle.
// Read and delete do not scan; insert first checks for rejection, then scans
// from rank 0 up to its insert rank; find scans from rank 0 to the found
// rank, or over all entries on a miss. in_stall is low again in the cycle
// out_valid rises, so the next transaction can be taken while a result
// still waits in the output register.
// A stalled result holds; a new result waits in its final state until the
// output register is free.
// Reset clears the entry count and sets list_limit to 16; stored entries are
// not cleared, and only ranks below the count are ever read.
// list_limit is written at byte addresses 0 to 3 of the register port.
module top_k_sorted_list import tksl_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] key,
  input  logic [31:0] payload,
  input  logic [3:0]  rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] entry_key,
  output logic [31:0] entry_payload,
  output logic [3:0]  entry_rank,
  output logic [4:0]  entry_count
);

  logic [4:0] list_limit;
  ctrl_cmd_t  ctrl;
  dp_flags_t  flags;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_LIST_LIMIT) begin
      list_limit <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == REG_LIST_LIMIT) ? {27'd0, list_limit} : '0;

  tksl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  tksl_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .flags         (flags),
    .list_limit    (list_limit),
    .cmd           (cmd),
    .key           (key),
    .payload       (payload),
    .rank          (rank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .entry_key     (entry_key),
    .entry_payload (entry_payload),
    .entry_rank    (entry_rank),
    .entry_count   (entry_count)
  );

endmodule
